// ----- rtl/segment_intersection_macros.svh -----
// Assertion macros shared by the segment intersection RTL.
`ifndef SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_INTERSECTION_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication: cons must hold whenever ante holds.
`define SI_ASSERT_IMPL(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("segment_intersection assertion failed");
// Next-cycle implication: cons must hold in the cycle after ante.
`define SI_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("segment_intersection assertion failed");
`else
`define SI_ASSERT_IMPL(label, ck, rs, ante, cons)
`define SI_ASSERT_NEXT(label, ck, rs, ante, cons)
`endif
`endif

// ----- rtl/si_pkg.sv -----
// Types, constants and helper functions of the segment intersection block.
`timescale 1ns / 1ps
package si_pkg;

  // Quotient bits produced by the divider; larger quotients clamp.
  localparam int QB = 41;
  // Magnitude width of a Cramer numerator.
  localparam int NM_W = 96;
  // Divider latency from registered operands to registered magnitude.
  localparam int DIV_LAT = QB + 2;
  // Clamp value for far crossings (2^40).
  localparam logic [QB:0] FAR_LIMIT = (QB + 1)'(64'd1 << 40);
  localparam logic [15:0] TOL_RESET = 16'd66;

  typedef struct packed {
    logic signed [31:0] start_a_x;
    logic signed [31:0] start_a_y;
    logic signed [31:0] dir_a_x;
    logic signed [31:0] dir_a_y;
    logic signed [31:0] start_b_x;
    logic signed [31:0] start_b_y;
    logic signed [31:0] dir_b_x;
    logic signed [31:0] dir_b_y;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
  } out_t;

  typedef struct packed {
    in_t  item;
    logic zdir;
  } queue_t;

  typedef struct packed {
    logic empty;
    logic almost_full;
  } fifo_stat_t;

  // One axis of the inside-segment test: o is crossing minus start.
  function automatic logic axis_ok(input logic [42:0] o, input logic [31:0] d,
                                   input logic [15:0] tol);
    logic [42:0] ao;
    logic [32:0] ad;
    logic [43:0] lim;
    logic        ok;
    ao  = o[42] ? (43'd0 - o) : o;
    ad  = d[31] ? (33'd0 - {d[31], d}) : {1'b0, d};
    lim = {1'b0, ao} + {28'd0, tol};
    if (d[31] && !o[42]) begin
      ok = 1'b0;
    end else if (!d[31] && (d != 32'd0) && o[42]) begin
      ok = 1'b0;
    end else if (d == 32'd0) begin
      ok = (ao <= {27'd0, tol});
    end else begin
      ok = ({11'd0, ad} >= lim);
    end
    return ok;
  endfunction

  // Saturate a 42-bit signed value to 32 bits.
  function automatic logic [31:0] sat32(input logic [41:0] p);
    logic [31:0] r;
    if (!p[41] && (p[40:31] != '0)) begin
      r = 32'h7fff_ffff;
    end else if (p[41] && (p[40:31] != '1)) begin
      r = 32'h8000_0000;
    end else begin
      r = p[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/si_front.sv -----
// Front end: accept items, flag zero directions, push into the queue.
`timescale 1ns / 1ps
module si_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  si_pkg::in_t        pair,
  input  si_pkg::fifo_stat_t stat,
  output logic               busy,
  output logic               push,
  output si_pkg::queue_t     push_data
);

  logic zdir_next;

  // Hold off new items once the queue is nearly full.
  assign busy = stat.almost_full;

  assign zdir_next = ((pair.dir_a_x == 32'sd0) && (pair.dir_a_y == 32'sd0)) ||
                     ((pair.dir_b_x == 32'sd0) && (pair.dir_b_y == 32'sd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= start && !busy;
    end
    push_data.item <= pair;
    push_data.zdir <= zdir_next;
  end

endmodule

// ----- rtl/si_fifo.sv -----
// Short item queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
`include "segment_intersection_macros.svh"
module si_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  si_pkg::queue_t     push_data,
  input  logic               pop,
  output si_pkg::queue_t     head,
  output si_pkg::fifo_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  si_pkg::queue_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign head             = mem[rd_ptr];
  assign stat.empty       = (count == '0);
  assign stat.almost_full = (count >= CW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  `SI_ASSERT_IMPL(a_no_overflow, clk, rst, push && !pop, count < CW'(DEPTH))
  `SI_ASSERT_IMPL(a_no_underflow, clk, rst, pop, count != '0)

endmodule

// ----- rtl/si_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, rounded and clamped.
`timescale 1ns / 1ps
module si_div (
  input  logic                      clk,
  input  logic [si_pkg::NM_W-1:0]   nm,
  input  logic [63:0]               dm,
  output logic [si_pkg::QB-1:0]     mag
);

  localparam int QB = si_pkg::QB;

  logic [63:0]   rem [0:QB];
  logic [QB-1:0] quo [0:QB];
  logic [QB-1:0] lo  [0:QB];
  logic [63:0]   dv  [0:QB];
  logic          ovf [0:QB];

  logic          up;
  logic [QB:0]   qr;

  // High numerator bits seed the remainder; if they already reach the
  // divisor the quotient is at least 2^QB and clamps.
  always_ff @(posedge clk) begin
    rem[0] <= 64'(nm[si_pkg::NM_W-1:QB]);
    ovf[0] <= (64'(nm[si_pkg::NM_W-1:QB]) >= dm);
    quo[0] <= '0;
    lo[0]  <= nm[QB-1:0];
    dv[0]  <= dm;
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [64:0] r2;
    logic [64:0] diff;
    logic        ge;
    assign r2   = {rem[k-1], lo[k-1][QB-1]};
    assign diff = r2 - {1'b0, dv[k-1]};
    assign ge   = (r2 >= {1'b0, dv[k-1]});
    always_ff @(posedge clk) begin
      rem[k] <= ge ? diff[63:0] : r2[63:0];
      quo[k] <= {quo[k-1][QB-2:0], ge};
      lo[k]  <= {lo[k-1][QB-2:0], 1'b0};
      dv[k]  <= dv[k-1];
      ovf[k] <= ovf[k-1];
    end
  end

  // Round half away from zero on the magnitude, then clamp.
  assign up = ({rem[QB], 1'b0} >= {1'b0, dv[QB]}) && (lo[QB] == '0);
  assign qr = {1'b0, quo[QB]} + (QB + 1)'(up);

  always_ff @(posedge clk) begin
    mag <= (ovf[QB] || (qr > si_pkg::FAR_LIMIT)) ? si_pkg::FAR_LIMIT[QB-1:0] : qr[QB-1:0];
  end

endmodule

// ----- rtl/si_back.sv -----
// Back end: Cramer products, division, inside test and result register.
`timescale 1ns / 1ps
module si_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop,
  input  si_pkg::queue_t head,
  input  logic [15:0]    tol,
  output logic           done,
  output si_pkg::out_t   result
);

  localparam int DL = si_pkg::DIV_LAT;

  typedef struct packed {
    si_pkg::in_t item;
    logic        nohit;
    logic        xneg;
    logic        yneg;
  } side_t;

  logic           v1, v2, v3, v4, v5, v6, v7, v8, v9;
  si_pkg::queue_t q1, q2, q3, q4, q5, q6;

  logic signed [63:0] p1, p2, p3, p4, p5, p6;
  logic [64:0]        det3, ac3, bc3, det4, det5, det6;
  logic signed [64:0] xh1, xh2, xl1, xl2, yh1, yh2, yl1, yl2;
  logic [65:0]        xh, xl, yh, yl;
  logic [97:0]        nx, ny, nx_neg, ny_neg;
  logic [64:0]        det_neg;

  logic [si_pkg::NM_W-1:0] nxm, nym;
  logic [63:0]             dm7;
  side_t                   sd7;

  side_t dl   [0:DL-1];
  logic  dl_v [0:DL-1];

  logic [si_pkg::QB-1:0] mag_x, mag_y;
  logic [41:0]           px8, py8, px9, py9;
  side_t                 sd8, sd9;
  logic [42:0]           oax, oay, obx, oby;
  logic                  hit_next;

  // Advance the valid chain of the arithmetic front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else begin
      v1 <= pop; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6;
    end
    if (pop) begin
      q1 <= head;
    end
    q2 <= q1; q3 <= q2; q4 <= q3; q5 <= q4; q6 <= q5;
  end

  // Stage 2: the six 32x32 products.
  always_ff @(posedge clk) begin
    p1 <= q1.item.dir_b_x * q1.item.dir_a_y;
    p2 <= q1.item.dir_b_y * q1.item.dir_a_x;
    p3 <= q1.item.dir_a_y * q1.item.start_a_x;
    p4 <= q1.item.dir_a_x * q1.item.start_a_y;
    p5 <= q1.item.dir_b_y * q1.item.start_b_x;
    p6 <= q1.item.dir_b_x * q1.item.start_b_y;
  end

  // Stage 3: determinant and line constants.
  always_ff @(posedge clk) begin
    det3 <= {p1[63], p1} - {p2[63], p2};
    ac3  <= {p3[63], p3} - {p4[63], p4};
    bc3  <= {p5[63], p5} - {p6[63], p6};
  end

  // Stage 4: partial products of direction times line constant halves.
  always_ff @(posedge clk) begin
    xh1  <= q3.item.dir_b_x * $signed(ac3[64:32]);
    xh2  <= q3.item.dir_a_x * $signed(bc3[64:32]);
    xl1  <= q3.item.dir_b_x * $signed({1'b0, ac3[31:0]});
    xl2  <= q3.item.dir_a_x * $signed({1'b0, bc3[31:0]});
    yh1  <= q3.item.dir_b_y * $signed(ac3[64:32]);
    yh2  <= q3.item.dir_a_y * $signed(bc3[64:32]);
    yl1  <= q3.item.dir_b_y * $signed({1'b0, ac3[31:0]});
    yl2  <= q3.item.dir_a_y * $signed({1'b0, bc3[31:0]});
    det4 <= det3;
  end

  // Stage 5: differences of the partial products.
  always_ff @(posedge clk) begin
    xh   <= {xh1[64], xh1} - {xh2[64], xh2};
    xl   <= {xl1[64], xl1} - {xl2[64], xl2};
    yh   <= {yh1[64], yh1} - {yh2[64], yh2};
    yl   <= {yl1[64], yl1} - {yl2[64], yl2};
    det5 <= det4;
  end

  // Stage 6: full numerators.
  always_ff @(posedge clk) begin
    nx   <= {xh[65:0], 32'd0} + {{32{xl[65]}}, xl};
    ny   <= {yh[65:0], 32'd0} + {{32{yl[65]}}, yl};
    det6 <= det5;
  end

  assign nx_neg  = 98'd0 - nx;
  assign ny_neg  = 98'd0 - ny;
  assign det_neg = 65'd0 - det6;

  // Stage 7: magnitudes and quotient signs.
  always_ff @(posedge clk) begin
    nxm       <= nx[97] ? nx_neg[si_pkg::NM_W-1:0] : nx[si_pkg::NM_W-1:0];
    nym       <= ny[97] ? ny_neg[si_pkg::NM_W-1:0] : ny[si_pkg::NM_W-1:0];
    dm7       <= det6[64] ? det_neg[63:0] : det6[63:0];
    sd7.item  <= q6.item;
    sd7.nohit <= q6.zdir || (det6 == '0);
    sd7.xneg  <= nx[97] ^ det6[64];
    sd7.yneg  <= ny[97] ^ det6[64];
  end

  si_div u_div_x (.clk(clk), .nm(nxm), .dm(dm7), .mag(mag_x));
  si_div u_div_y (.clk(clk), .nm(nym), .dm(dm7), .mag(mag_y));

  // Side data rides alongside the dividers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dl_v[0] <= 1'b0;
    end else begin
      dl_v[0] <= v7;
    end
    dl[0] <= sd7;
  end

  for (genvar i = 1; i < DL; i++) begin : g_dl
    always_ff @(posedge clk) begin
      if (rst) begin
        dl_v[i] <= 1'b0;
      end else begin
        dl_v[i] <= dl_v[i-1];
      end
      dl[i] <= dl[i-1];
    end
  end

  // Stage 8: signed crossing point.
  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= dl_v[DL-1];
    end
    px8 <= dl[DL-1].xneg ? (42'd0 - {1'b0, mag_x}) : {1'b0, mag_x};
    py8 <= dl[DL-1].yneg ? (42'd0 - {1'b0, mag_y}) : {1'b0, mag_y};
    sd8 <= dl[DL-1];
  end

  assign oax = {px8[41], px8} - {{11{sd8.item.start_a_x[31]}}, sd8.item.start_a_x};
  assign oay = {py8[41], py8} - {{11{sd8.item.start_a_y[31]}}, sd8.item.start_a_y};
  assign obx = {px8[41], px8} - {{11{sd8.item.start_b_x[31]}}, sd8.item.start_b_x};
  assign oby = {py8[41], py8} - {{11{sd8.item.start_b_y[31]}}, sd8.item.start_b_y};

  logic [42:0] oax9, oay9, obx9, oby9;

  // Stage 9: offsets from each start point.
  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= v8;
    end
    oax9 <= oax; oay9 <= oay; obx9 <= obx; oby9 <= oby;
    px9  <= px8; py9 <= py8;
    sd9  <= sd8;
  end

  assign hit_next = !sd9.nohit &&
                    si_pkg::axis_ok(oax9, sd9.item.dir_a_x, tol) &&
                    si_pkg::axis_ok(oay9, sd9.item.dir_a_y, tol) &&
                    si_pkg::axis_ok(obx9, sd9.item.dir_b_x, tol) &&
                    si_pkg::axis_ok(oby9, sd9.item.dir_b_y, tol);

  // Stage 10: result register, zero point on a miss.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v9;
    end
    result.hit     <= hit_next;
    result.cross_x <= hit_next ? si_pkg::sat32(px9) : 32'sd0;
    result.cross_y <= hit_next ? si_pkg::sat32(py9) : 32'sd0;
  end

endmodule

// ----- rtl/segment_intersection.sv -----
// Top level of the segment intersection block.
`timescale 1ns / 1ps
`include "segment_intersection_macros.svh"
// Intersects two segments, each given as a start point and a direction in
// signed Q16.16, and reports a hit flag with the crossing point. Issue an item
// by raising start while busy is low; one item may enter every cycle while
// busy stays low. Each result appears on result for exactly one cycle with
// done high, in issue order; the receiver cannot stall it, so capture it when
// done is high. Most of the pipeline is the pipelined divider (41 quotient
// stages plus its operand and rounding registers) that forms each coordinate
// quotient; the front end, queue and multiply stages lie ahead of it, and the
// crossing point, inside test and result registers behind it. Parallel lines,
// zero directions and crossings outside either segment give hit low and a
// zero point; a hit beyond the 32-bit range saturates. inside_tolerance is
// written on the cfg channel (always ready) and should change only while no
// item is in flight.
module segment_intersection #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  si_pkg::in_t  pair,
  output logic         done,
  output si_pkg::out_t result,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);

  logic               push;
  si_pkg::queue_t     push_data;
  si_pkg::queue_t     head;
  si_pkg::fifo_stat_t stat;
  logic               pop;
  logic [15:0]        tol;

  assign cfg_ready = 1'b1;

  // Tolerance register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= si_pkg::TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tol <= cfg_data;
    end
  end

  // The back end drains the queue every cycle it holds an item.
  assign pop = !stat.empty;

  si_front u_front (
    .clk(clk), .rst(rst), .start(start), .pair(pair), .stat(stat),
    .busy(busy), .push(push), .push_data(push_data)
  );

  si_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .pop(pop), .head(head), .stat(stat)
  );

  si_back u_back (
    .clk(clk), .rst(rst), .pop(pop), .head(head), .tol(tol),
    .done(done), .result(result)
  );

  `SI_ASSERT_IMPL(a_miss_zero, clk, rst, done && !result.hit, {result.cross_x, result.cross_y} == '0)
  `SI_ASSERT_NEXT(a_cfg_write, clk, rst, cfg_valid && cfg_ready, tol == $past(cfg_data))

endmodule

// ----- test/segment_intersection_tb.sv -----
// Self-checking testbench for the segment intersection block.
`timescale 1ns / 1ps

// Scoreboard: predicts each crossing and holds predictions in issue order.
class crossing_scoreboard;
  typedef logic signed [127:0] wide_t;

  si_pkg::out_t pending[$];
  longint       tolerance;

  function new();
    tolerance = longint'(si_pkg::TOL_RESET);
  endfunction

  // Rounded quotient, ties away from zero, clamped to 2^40 in magnitude.
  function longint round_div(wide_t num, wide_t den);
    logic [127:0] nm, dm, q, r;
    nm = num[127] ? -num : num;
    dm = den[127] ? -den : den;
    q  = nm / dm;
    r  = nm % dm;
    if (r >= dm - r) q = q + 1;
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    return (num[127] != den[127]) ? -longint'(q) : longint'(q);
  endfunction

  function bit axis_ok(longint s, longint d, longint p);
    longint o, ao, ad;
    o  = p - s;
    ao = (o < 0) ? -o : o;
    ad = (d < 0) ? -d : d;
    if (d < 0 && o >= 0) return 0;
    if (d > 0 && o < 0) return 0;
    if (d == 0) return ao <= tolerance;
    return ad >= ao + tolerance;
  endfunction

  function logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Note an accepted pair: work out and queue its crossing.
  function void note_pair(si_pkg::in_t p);
    si_pkg::out_t r;
    wide_t ax, ay, dax, day, bx, by, dbx, dby, det, ac, bc, nx, ny;
    longint px, py;
    r = '0;
    ax = wide_t'(p.start_a_x); ay = wide_t'(p.start_a_y);
    dax = wide_t'(p.dir_a_x);  day = wide_t'(p.dir_a_y);
    bx = wide_t'(p.start_b_x); by = wide_t'(p.start_b_y);
    dbx = wide_t'(p.dir_b_x);  dby = wide_t'(p.dir_b_y);
    det = dby * (-dax) - (-dbx) * day;
    if (!((dax == 0 && day == 0) || (dbx == 0 && dby == 0)) && det != 0) begin
      ac = day * ax + (-dax) * ay;
      bc = dby * bx + (-dbx) * by;
      nx = (-dax) * bc - (-dbx) * ac;
      ny = dby * ac - day * bc;
      px = round_div(nx, det);
      py = round_div(ny, det);
      if (axis_ok(longint'(ax), longint'(dax), px) &&
          axis_ok(longint'(ay), longint'(day), py) &&
          axis_ok(longint'(bx), longint'(dbx), px) &&
          axis_ok(longint'(by), longint'(dby), py)) begin
        r.hit = 1'b1;
        r.cross_x = clip32(px);
        r.cross_y = clip32(py);
      end
    end
    pending.push_back(r);
  endfunction

  // Check one result against the oldest prediction; return 1 on mismatch.
  function bit check_result(si_pkg::out_t got, output string msg);
    si_pkg::out_t want;
    if (pending.size() == 0) begin
      msg = $sformatf("unexpected result %0b %h %h", got.hit, got.cross_x, got.cross_y);
      return 1;
    end
    want = pending.pop_front();
    if (got.hit !== want.hit || got.cross_x !== want.cross_x ||
        got.cross_y !== want.cross_y) begin
      msg = $sformatf("result %0b %h %h, predicted %0b %h %h", got.hit, got.cross_x,
                      got.cross_y, want.hit, want.cross_x, want.cross_y);
      return 1;
    end
    return 0;
  endfunction
endclass

module segment_intersection_tb;

  // Latency of the block plus some margin.
  localparam int DRAIN_CYCLES = 70;

  logic         clk;
  logic         rst;
  logic         start;
  logic         busy;
  si_pkg::in_t  pair;
  logic         done;
  si_pkg::out_t result;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [15:0]  cfg_data;

  crossing_scoreboard crossings;
  int mismatches = 0;

  segment_intersection DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pair(pair),
    .done(done), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Sample results mid-cycle, away from the clock edge; each one lives one cycle.
  always @(negedge clk) begin
    string msg;
    if (!rst && done === 1'b1) begin
      if (crossings.check_result(result, msg)) report_mismatch(msg);
    end
  end

  // Issue one item after a random gap; hold it until busy is low at an edge.
  task automatic send_pair(si_pkg::in_t p);
    int gap;
    bit was_busy;
    gap = $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    pair  <= p;
    forever begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
      if (!was_busy) break;
    end
    crossings.note_pair(p);
  endtask

  // Drain all in-flight items, then write the tolerance register.
  task automatic write_tolerance(logic [15:0] value);
    bit was_ready;
    start <= 1'b0;
    @(posedge clk);
    while (crossings.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    forever begin
      @(negedge clk);
      was_ready = cfg_ready;
      @(posedge clk);
      if (was_ready) break;
    end
    cfg_valid <= 1'b0;
    crossings.tolerance = longint'(value);
  endtask

  function automatic si_pkg::in_t make_pair(int ax, int ay, int dax, int day,
                                            int bx, int by, int dbx, int dby);
    si_pkg::in_t p;
    p.start_a_x = ax; p.start_a_y = ay; p.dir_a_x = dax; p.dir_a_y = day;
    p.start_b_x = bx; p.start_b_y = by; p.dir_b_x = dbx; p.dir_b_y = dby;
    return p;
  endfunction

  function automatic int rand_dir();
    int d;
    d = int'($urandom_range(1, 1 << 20));
    return $urandom_range(0, 1) ? d : -d;
  endfunction

  // Build a pair whose segments meet near a chosen point, with random reach.
  function automatic si_pkg::in_t crossing_pair();
    int px, py, dax, day, dbx, dby;
    int ka, kb;
    px = int'($urandom) >>> $urandom_range(4, 12);
    py = int'($urandom) >>> $urandom_range(4, 12);
    dax = rand_dir(); day = rand_dir(); dbx = rand_dir(); dby = rand_dir();
    if ($urandom_range(0, 7) == 0) dax = 0;
    if ($urandom_range(0, 7) == 0) dby = 0;
    // k of 16 lands on the segment end; beyond it the crossing misses
    ka = $urandom_range(0, 18);
    kb = $urandom_range(0, 18);
    return make_pair(px - (dax * ka) / 16, py - (day * ka) / 16, dax, day,
                     px - (dbx * kb) / 16, py - (dby * kb) / 16, dbx, dby);
  endfunction

  function automatic si_pkg::in_t random_pair();
    si_pkg::in_t p;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      p = crossing_pair();
    end else begin
      p = si_pkg::in_t'({$urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom});
      // turn some into near-parallel, zero-direction and antiparallel cases
      if (sel == 7) begin
        p.dir_b_x = p.dir_a_x;
        p.dir_b_y = p.dir_a_y + int'($urandom_range(0, 2)) - 1;
      end else if (sel == 8) begin
        p.dir_a_x = 0;
        p.dir_a_y = 0;
      end else if (sel == 9) begin
        p.dir_b_x = -p.dir_a_x;
        p.dir_b_y = -p.dir_a_y;
      end
    end
    return p;
  endfunction

  task automatic run_directed();
    int one;
    one = 32'h0001_0000;
    // plain crossing at the origin
    send_pair(make_pair(-one, 0, 2 * one, 0, 0, -one, 0, 2 * one));
    // zero direction on either side
    send_pair(make_pair(0, 0, 0, 0, 0, -one, 0, 2 * one));
    send_pair(make_pair(-one, 0, 2 * one, 0, 5, 7, 0, 0));
    // parallel and collinear lines
    send_pair(make_pair(0, 0, one, one, one, 0, one, one));
    send_pair(make_pair(0, 0, one, one, one, one, -one, -one));
    // crossing exactly at the end of a segment, and just short of it
    send_pair(make_pair(0, 0, one, 0, one, -one, 0, 2 * one));
    send_pair(make_pair(0, 0, one + 66, 0, one, -one, 0, 2 * one));
    // crossing behind the start
    send_pair(make_pair(0, 0, one, 0, -one, -one, 0, 2 * one));
    // saturation of the crossing x
    send_pair(make_pair(32'h6000_0000, 0, 32'h7fff_ffff, 32'h4000_0000,
                        32'h6000_0000, 32'h4000_0000, 32'h7fff_ffff, -32'h4000_0000));
    // saturation of the crossing y, negative side
    send_pair(make_pair(0, 32'ha000_0000, 32'h4000_0000, 32'h8000_0000,
                        32'h4000_0000, 32'ha000_0000, -32'h4000_0000, 32'h8000_0000));
    // far crossing of nearly parallel lines
    send_pair(make_pair(0, 0, 32'h7fff_ffff, 32'h7fff_fffe, 0, one, 32'h7fff_ffff,
                        32'h7fff_ffff));
    // field extremes
    send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    send_pair(make_pair(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send_pair(make_pair(-1, -1, -1, -1, 1, 1, 1, -1));
    send_pair(make_pair(0, 0, 32'h8000_0000, 0, -one, 32'h8000_0000, 0, 32'h7fff_ffff));
    send_pair(make_pair(32'hffff_ffff, 0, 32'h8000_0000, 32'h7fff_ffff,
                        32'h8000_0000, 0, 32'h7fff_ffff, 32'h8000_0000));
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      send_pair(random_pair());
      // drop into a run with no gaps now and then
      if ($urandom_range(0, 99) == 0) begin
        for (int j = 0; j < 20; j++) begin
          pair  <= random_pair();
          start <= 1'b1;
          @(negedge clk);
          if (!busy) crossings.note_pair(pair);
          @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    crossings = new();
    rst       = 1'b1;
    start     = 1'b0;
    pair      = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset tolerance first, then the extremes, a random one and the reset value again
    run_directed();
    run_random(300);
    write_tolerance(16'd0);
    run_directed();
    run_random(300);
    write_tolerance(16'hffff);
    run_directed();
    run_random(300);
    write_tolerance(16'($urandom_range(1, 16'hfffe)));
    run_random(300);
    write_tolerance(si_pkg::TOL_RESET);
    run_random(100);

    start <= 1'b0;
    @(posedge clk);
    while (crossings.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
